// File: design/ntp_pkg.sv
// ntp_pkg: shared types and constants for the nearest triangle projection block
// request payload structs and register index codes; no dependencies
`default_nettype none

package ntp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_POINT_X = 3'd0;
    localparam logic [2:0] REG_POINT_Y = 3'd1;
    localparam logic [2:0] REG_POINT_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X   = 3'd3;
    localparam logic [2:0] REG_DIR_Y   = 3'd4;
    localparam logic [2:0] REG_DIR_Z   = 3'd5;

    localparam logic [31:0] DIR_Z_RESET = 32'h0001_0000;
    localparam logic [30:0] Q130_ONE    = 31'h4000_0000;
    localparam logic [31:0] MAG_MAX     = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [15:0]        tri_index;
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_z;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
        logic               last_triangle;
    } t_tri_req;

    typedef struct packed {
        logic [15:0]        best_index;
        logic [30:0]        lambda_coord;
        logic [30:0]        mu_coord;
        logic signed [31:0] eta_dist;
        logic               found;
    } t_res_req;

endpackage

`default_nettype wire

// File: design/nearest_triangle_projection.sv
// nearest_triangle_projection: projects a point onto a stream of triangles and keeps
// the nearest hit; one shared 33x33 multiplier and one shift-subtract divider. uses ntp_pkg
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  tri     | in        | i_tri_valid/o_stall | ntp_pkg::t_tri_req
//  res     | out       | o_res_valid/i_stall | ntp_pkg::t_res_req
//  cfg     | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// a determinant: six minor products, nine 33 x 23 slice products, one store
// a degenerate triangle ends after den, a miss after the inside test, a hit not nearer
// after the eta divide, a new nearest hit after lambda and mu divides too (DIV_BITS = 133)
// a last triangle adds S_OUT. reset is synchronous active low and clears control state
// and the search. o_stall stays high while busy and while a result waits under i_stall
`default_nettype none

module nearest_triangle_projection #(
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_tri_valid,
    output logic                   o_stall,
    input  ntp_pkg::t_tri_req      i_tri,
    output logic                   o_res_valid,
    input  wire                    i_stall,
    output ntp_pkg::t_res_req      o_res,
    input  wire                    i_cfg_we,
    input  wire [2:0]              i_cfg_index,
    input  wire [31:0]             i_cfg_data
);
    import ntp_pkg::*;

    // widths: edges 33b, minors 67b, determinants 102b
    localparam int EW   = 33;
    localparam int MW   = 2 * EW + 1;
    localparam int DW   = MW + EW + 2;
    localparam int NUMW = DW + 31;          // numerator after shift by up to 30
    localparam int DIV_BITS = NUMW;
    localparam int DCW  = $clog2(DIV_BITS + 1);
    localparam int SL   = 23;               // minor slice width for the row terms
    localparam logic [63:0] BOUND_FULL = 64'd1000 << FRAC_BITS;
    localparam logic [31:0] BOUND = (BOUND_FULL > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : BOUND_FULL[31:0];
    localparam logic [INDEX_BITS-1:0] IDX_MASK = '1;

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MINOR = 4'd1;
    localparam logic [3:0] S_DET   = 4'd2;
    localparam logic [3:0] S_NEXT  = 4'd3;
    localparam logic [3:0] S_TEST  = 4'd4;
    localparam logic [3:0] S_DIVE  = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_DIVL  = 4'd7;
    localparam logic [3:0] S_DIVM  = 4'd8;
    localparam logic [3:0] S_END   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // config registers
    logic signed [31:0] r_pt [3];
    logic signed [31:0] r_dir [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0] <= '0; r_pt[1] <= '0; r_pt[2] <= '0;
            r_dir[0] <= '0; r_dir[1] <= '0; r_dir[2] <= DIR_Z_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINT_X: r_pt[0] <= i_cfg_data;
                REG_POINT_Y: r_pt[1] <= i_cfg_data;
                REG_POINT_Z: r_pt[2] <= i_cfg_data;
                REG_DIR_X:   r_dir[0] <= i_cfg_data;
                REG_DIR_Y:   r_dir[1] <= i_cfg_data;
                REG_DIR_Z:   r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer registers
    logic [3:0]  r_state;
    logic [1:0]  r_det;       // 0 den, 1 lambda, 2 mu, 3 eta
    logic [1:0]  r_mi;        // minor / term index
    logic [1:0]  r_part;      // minor slice within a row term
    logic        r_half;      // product half within a minor
    logic signed [EW-1:0] r_a [3];
    logic signed [EW-1:0] r_b [3];
    logic signed [EW-1:0] r_d [3];
    logic signed [MW-1:0] r_minor [3];
    logic signed [MW-1:0] r_p0;
    logic signed [DW-1:0] r_acc;
    logic signed [DW-1:0] r_dv [4];
    logic [INDEX_BITS-1:0] r_idx;
    logic        r_last;

    // search state
    logic [31:0] r_best_abs;
    logic [INDEX_BITS-1:0] r_best_tri;
    logic [30:0] r_best_l, r_best_m;
    logic [31:0] r_best_eta;
    logic        r_hit;
    logic [31:0] r_mag;
    logic        r_eneg;

    // divider
    logic [NUMW-1:0] r_quo;
    logic [DW-1:0]   r_rem;
    logic [DCW-1:0]  r_dcnt;
    logic            r_dbusy;

    t_res_req r_res;
    logic     r_res_valid;

    assign o_stall     = (r_state != S_IDLE) || r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // matrix column entries for the current determinant: rows r1,r2,r3
    function automatic logic signed [EW-1:0] col(input logic [1:0] det,
        input logic [1:0] row,
        input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
        input logic signed [EW-1:0] d, input logic signed [EW-1:0] c);
        logic signed [EW-1:0] v;
        begin
            v = c;
            case (row)
                2'd0: v = (det == 2'd1) ? d : a;
                2'd1: v = (det == 2'd2) ? d : b;
                default: v = (det == 2'd3) ? d : c;
            endcase
            return v;
        end
    endfunction

    // operand selection for the shared multiplier
    logic [1:0] m_j, m_k;
    logic signed [EW-1:0] m_x, m_y;
    logic signed [2*EW-1:0] m_prod;
    logic signed [MW-1:0]   m_prod_w;
    logic signed [EW-1:0] c_sel [3];

    always_comb begin
        for (int i = 0; i < 3; i++) c_sel[i] = EW'(r_dir[i]);
        // minor r_mi uses columns (j,k): 0->(1,2) 1->(0,2) 2->(0,1)
        m_j = (r_mi == 2'd0) ? 2'd1 : 2'd0;
        m_k = (r_mi == 2'd2) ? 2'd1 : 2'd2;
        if (r_state == S_MINOR) begin
            if (!r_half) begin
                m_x = col(r_det, 2'd1, r_a[m_j], r_b[m_j], r_d[m_j], c_sel[m_j]);
                m_y = col(r_det, 2'd2, r_a[m_k], r_b[m_k], r_d[m_k], c_sel[m_k]);
            end else begin
                m_x = col(r_det, 2'd1, r_a[m_k], r_b[m_k], r_d[m_k], c_sel[m_k]);
                m_y = col(r_det, 2'd2, r_a[m_j], r_b[m_j], r_d[m_j], c_sel[m_j]);
            end
        end else begin
            m_x = col(r_det, 2'd0, r_a[r_mi], r_b[r_mi], r_d[r_mi], c_sel[r_mi]);
            // low and middle slices unsigned, top slice carries the sign
            case (r_part)
                2'd0: m_y = EW'({1'b0, r_minor[r_mi][SL-1:0]});
                2'd1: m_y = EW'({1'b0, r_minor[r_mi][2*SL-1:SL]});
                default: m_y = EW'($signed(r_minor[r_mi][MW-1:2*SL]));
            endcase
        end
        m_prod   = m_x * m_y;
        m_prod_w = MW'(m_prod);
    end

    // slice product weighted by its position in the minor
    logic signed [DW-1:0] t_prod;
    always_comb begin
        case (r_part)
            2'd1: t_prod = DW'(m_prod) <<< SL;
            2'd2: t_prod = DW'(m_prod) <<< (2 * SL);
            default: t_prod = DW'(m_prod);
        endcase
    end

    // normalized determinants (sign folded into den)
    logic signed [DW-1:0] den_abs, nl_s, nm_s, ne_s;
    logic signed [DW-1:0] slack;
    always_comb begin
        if (r_dv[0][DW-1]) begin
            den_abs = -r_dv[0]; nl_s = -r_dv[1]; nm_s = -r_dv[2]; ne_s = -r_dv[3];
        end else begin
            den_abs = r_dv[0]; nl_s = r_dv[1]; nm_s = r_dv[2]; ne_s = r_dv[3];
        end
        slack = den_abs - nl_s - nm_s;
    end

    // divider step
    logic [DW:0] d_trial;
    assign d_trial = {r_rem, r_quo[NUMW-1]} - {1'b0, den_abs};

    // quotient views
    logic [31:0] q_mag;
    assign q_mag = (|r_quo[NUMW-1:31]) ? MAG_MAX : {1'b0, r_quo[30:0]};

    logic [NUMW-1:0] n_num;
    always_comb begin
        n_num = '0;
        case (r_state)
            S_TEST: n_num = NUMW'(ne_s[DW-1] ? -ne_s : ne_s) << FRAC_BITS;
            S_CMP:  n_num = NUMW'(nl_s) << 30;
            S_DIVL: n_num = NUMW'(nm_s) << 30;
            default: n_num = '0;
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_dbusy     <= 1'b0;
            r_best_abs  <= BOUND;
            r_hit       <= 1'b0;
            r_best_tri  <= '0; r_best_l <= '0; r_best_m <= '0; r_best_eta <= '0;
        end else begin
            if (r_res_valid && !i_stall) r_res_valid <= 1'b0;
            // divider iterations run underneath the divide states
            if (r_dbusy) begin
                if (!d_trial[DW]) begin
                    r_rem <= d_trial[DW-1:0];
                    r_quo <= {r_quo[NUMW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_quo[NUMW-1]};
                    r_quo <= {r_quo[NUMW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == DCW'(1)) r_dbusy <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_tri_valid && !r_res_valid) begin
                        r_a[0] <= EW'(i_tri.v1_x) - EW'(i_tri.v0_x);
                        r_a[1] <= EW'(i_tri.v1_y) - EW'(i_tri.v0_y);
                        r_a[2] <= EW'(i_tri.v1_z) - EW'(i_tri.v0_z);
                        r_b[0] <= EW'(i_tri.v2_x) - EW'(i_tri.v0_x);
                        r_b[1] <= EW'(i_tri.v2_y) - EW'(i_tri.v0_y);
                        r_b[2] <= EW'(i_tri.v2_z) - EW'(i_tri.v0_z);
                        r_d[0] <= EW'(r_pt[0]) - EW'(i_tri.v0_x);
                        r_d[1] <= EW'(r_pt[1]) - EW'(i_tri.v0_y);
                        r_d[2] <= EW'(r_pt[2]) - EW'(i_tri.v0_z);
                        r_idx  <= INDEX_BITS'(i_tri.tri_index) & IDX_MASK;
                        r_last <= i_tri.last_triangle;
                        r_det  <= 2'd0; r_mi <= 2'd0; r_half <= 1'b0;
                        r_state <= S_MINOR;
                    end
                end
                S_MINOR: begin
                    if (!r_half) begin
                        r_p0 <= m_prod_w;
                        r_half <= 1'b1;
                    end else begin
                        r_minor[r_mi] <= r_p0 - m_prod_w;
                        r_half <= 1'b0;
                        if (r_mi == 2'd2) begin
                            r_mi <= 2'd0; r_part <= 2'd0; r_acc <= '0; r_state <= S_DET;
                        end else r_mi <= r_mi + 1'b1;
                    end
                end
                S_DET: begin
                    r_acc <= (r_mi == 2'd1) ? r_acc - t_prod : r_acc + t_prod;
                    if (r_part == 2'd2) begin
                        r_part <= 2'd0;
                        if (r_mi == 2'd2) begin
                            r_mi <= 2'd0; r_state <= S_NEXT;
                        end else r_mi <= r_mi + 1'b1;
                    end else r_part <= r_part + 1'b1;
                end
                S_NEXT: begin
                    r_dv[r_det] <= r_acc;
                    if (r_det == 2'd0 && r_acc == '0) r_state <= S_END;
                    else if (r_det == 2'd3) r_state <= S_TEST;
                    else begin
                        r_det <= r_det + 1'b1; r_state <= S_MINOR;
                    end
                end
                S_TEST: begin
                    if (!nl_s[DW-1] && !nm_s[DW-1] && !slack[DW-1]) begin
                        r_eneg <= ne_s[DW-1];
                        r_quo <= n_num; r_rem <= '0;
                        r_dcnt <= DCW'(DIV_BITS); r_dbusy <= 1'b1;
                        r_state <= S_DIVE;
                    end else r_state <= S_END;
                end
                S_DIVE: if (!r_dbusy) begin
                    r_mag <= q_mag;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_mag < r_best_abs) begin
                        r_best_abs <= r_mag;
                        r_best_tri <= r_idx;
                        r_best_eta <= r_eneg ? r_mag : 32'd0 - r_mag;
                        r_hit <= 1'b1;
                        r_quo <= n_num; r_rem <= '0;
                        r_dcnt <= DCW'(DIV_BITS); r_dbusy <= 1'b1;
                        r_state <= S_DIVL;
                    end else r_state <= S_END;
                end
                S_DIVL: if (!r_dbusy) begin
                    r_best_l <= r_quo[30:0];
                    r_quo <= n_num; r_rem <= '0;
                    r_dcnt <= DCW'(DIV_BITS); r_dbusy <= 1'b1;
                    r_state <= S_DIVM;
                end
                S_DIVM: if (!r_dbusy) begin
                    r_best_m <= r_quo[30:0];
                    r_state <= S_END;
                end
                S_END: begin
                    if (r_last) r_state <= S_OUT;
                    else r_state <= S_IDLE;
                end
                S_OUT: begin
                    r_res.best_index   <= r_hit ? 16'(r_best_tri) : 16'd0;
                    r_res.lambda_coord <= r_hit ? r_best_l : 31'd0;
                    r_res.mu_coord     <= r_hit ? r_best_m : 31'd0;
                    r_res.eta_dist     <= r_hit ? r_best_eta : 32'd0;
                    r_res.found        <= r_hit;
                    r_res_valid <= 1'b1;
                    r_best_abs <= BOUND; r_hit <= 1'b0;
                    r_best_tri <= '0; r_best_l <= '0; r_best_m <= '0; r_best_eta <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/ntp_checker.sv
// ntp_checker: port-level checks for nearest_triangle_projection
// bound to the top level below; uses ntp_pkg
`default_nettype none

module ntp_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_tri_valid,
    input wire               o_stall,
    input wire               o_res_valid,
    input wire               i_stall,
    input ntp_pkg::t_res_req o_res
);
    import ntp_pkg::*;

    // a result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_stall |=> o_res_valid && $stable(o_res))
        else $error("result dropped under stall");

    // no hit means an all-zero result
    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.found |-> o_res.best_index == 16'd0 &&
        o_res.lambda_coord == 31'd0 && o_res.mu_coord == 31'd0 && o_res.eta_dist == 32'd0)
        else $error("empty result not zero");

    // a request accepted keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tri_valid && !o_stall |=> o_stall)
        else $error("block idle after request");

    // barycentric weights are within one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.lambda_coord <= Q130_ONE && o_res.mu_coord <= Q130_ONE)
        else $error("weight out of range");

endmodule

bind nearest_triangle_projection ntp_checker u_ntp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tri_valid(i_tri_valid), .o_stall(o_stall),
    .o_res_valid(o_res_valid), .i_stall(i_stall), .o_res(o_res)
);

`default_nettype wire

// File: dv/ntp_checker.sv
// ntp_scoreboard: watches the triangle, result and register ports of the projection block,
// predicts each scan result and compares it field by field; depends on ntp_pkg
module ntp_scoreboard (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_tri_valid,
    input  wire                i_tri_stall,
    input  ntp_pkg::t_tri_req  i_tri,
    input  wire                i_res_valid,
    input  wire                i_res_stall,
    input  ntp_pkg::t_res_req  i_res,
    input  wire                i_cfg_we,
    input  wire [2:0]          i_cfg_index,
    input  wire [31:0]         i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import ntp_pkg::*;

    localparam int FRAC = 16;
    localparam logic [31:0] BOUND_RESET = 32'd1000 << FRAC;

    typedef logic signed [191:0] t_wide;

    // register copy and running search state
    logic signed [31:0] pt_x, pt_y, pt_z, dr_x, dr_y, dr_z;
    logic [31:0] near_mag;
    logic [15:0] near_tri;
    logic [30:0] near_lambda, near_mu;
    logic [31:0] near_eta;
    logic        near_hit;
    t_res_req    scan_results[$];

    assign o_pending = scan_results.size();

    function automatic t_wide det3(t_wide ax, t_wide ay, t_wide az, t_wide bx, t_wide by,
                                   t_wide bz, t_wide cx, t_wide cy, t_wide cz);
        return ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx) + az * (bx * cy - by * cx);
    endfunction

    task automatic clear_scan();
        near_mag    = BOUND_RESET;
        near_tri    = '0;
        near_lambda = '0;
        near_mu     = '0;
        near_eta    = '0;
        near_hit    = 1'b0;
    endtask

    // project the point onto one triangle and keep the nearest hit
    task automatic project_triangle(t_tri_req r);
        t_wide ax, ay, az, bx, by, bz, dx, dy, dz, cx, cy, cz, o;
        t_wide den, nl, nm, ne;
        logic [191:0] q;
        logic [31:0] mag;
        logic eta_neg;
        t_res_req res;
        o = $signed(r.v0_x); ax = $signed(r.v1_x) - o; bx = $signed(r.v2_x) - o;
        dx = $signed(pt_x) - o;
        o = $signed(r.v0_y); ay = $signed(r.v1_y) - o; by = $signed(r.v2_y) - o;
        dy = $signed(pt_y) - o;
        o = $signed(r.v0_z); az = $signed(r.v1_z) - o; bz = $signed(r.v2_z) - o;
        dz = $signed(pt_z) - o;
        cx = $signed(dr_x); cy = $signed(dr_y); cz = $signed(dr_z);
        den = det3(ax, ay, az, bx, by, bz, cx, cy, cz);
        if (den != 0) begin
            nl = det3(dx, dy, dz, bx, by, bz, cx, cy, cz);
            nm = det3(ax, ay, az, dx, dy, dz, cx, cy, cz);
            ne = det3(ax, ay, az, bx, by, bz, dx, dy, dz);
            if (den < 0) begin
                den = -den; nl = -nl; nm = -nm; ne = -ne;
            end
            if (nl >= 0 && nm >= 0 && den - nl - nm >= 0) begin
                eta_neg = ne < 0;
                q = (eta_neg ? -ne : ne);
                q = (q << FRAC) / $unsigned(den);
                mag = (q > 192'(MAG_MAX)) ? MAG_MAX : q[31:0];
                if (mag < near_mag) begin
                    near_mag = mag;
                    near_tri = r.tri_index;
                    q = $unsigned(nl);
                    q = (q << 30) / $unsigned(den);
                    near_lambda = q[30:0];
                    q = $unsigned(nm);
                    q = (q << 30) / $unsigned(den);
                    near_mu = q[30:0];
                    near_eta = eta_neg ? mag : -mag;
                    near_hit = 1'b1;
                end
            end
        end
        if (r.last_triangle) begin
            if (near_hit) begin
                res = '{near_tri, near_lambda, near_mu, near_eta, 1'b1};
            end else begin
                res = '0;
            end
            scan_results.push_back(res);
            clear_scan();
        end
    endtask

    // sample all three ports at the rising edge
    always @(posedge i_clk) begin
        t_res_req exp_res;
        if (!i_rst_n) begin
            pt_x = '0; pt_y = '0; pt_z = '0;
            dr_x = '0; dr_y = '0; dr_z = DIR_Z_RESET;
            clear_scan();
            scan_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POINT_X: pt_x = i_cfg_data;
                    REG_POINT_Y: pt_y = i_cfg_data;
                    REG_POINT_Z: pt_z = i_cfg_data;
                    REG_DIR_X:   dr_x = i_cfg_data;
                    REG_DIR_Y:   dr_y = i_cfg_data;
                    REG_DIR_Z:   dr_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (scan_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %p", i_res);
                end else begin
                    exp_res = scan_results.pop_front();
                    if (exp_res.best_index !== i_res.best_index
                            || exp_res.lambda_coord !== i_res.lambda_coord
                            || exp_res.mu_coord !== i_res.mu_coord
                            || exp_res.eta_dist !== i_res.eta_dist
                            || exp_res.found !== i_res.found) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p actual %p", exp_res, i_res);
                    end
                end
            end
            if (i_tri_valid && !i_tri_stall) project_triangle(i_tri);
        end
    end

endmodule

// File: dv/testbench.sv
// testbench: drives triangle scans and register settings into nearest_triangle_projection
// and gives the verdict; depends on ntp_pkg and ntp_scoreboard
module testbench;
    import ntp_pkg::*;

    localparam int LIMIT   = 4000000;
    localparam int SETTLE  = 2000;
    localparam int N_ITEMS = 850;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      tri_valid = 1'b0;
    logic      tri_stall;
    t_tri_req  tri_req = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    t_res_req  res;
    logic      cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int        errors, pending;
    int        cycles = 0;
    logic      long_hold_req = 1'b0;
    int        sent = 0;
    int        burst_left = 0;
    logic [15:0] next_index = '0;
    logic signed [31:0] cur_px, cur_py, cur_pz;

    always #2 clk = ~clk;

    nearest_triangle_projection u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_tri_valid(tri_valid), .o_stall(tri_stall), .i_tri(tri_req),
        .o_res_valid(res_valid), .i_stall(res_stall), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ntp_scoreboard u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_tri_valid(tri_valid), .i_tri_stall(tri_stall), .i_tri(tri_req),
        .i_res_valid(res_valid), .i_res_stall(res_stall), .i_res(res),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // timeout
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode_left, mode, hold_left;
        logic hold_done;
        mode_left = 0; mode = 0; hold_left = 0; hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(2);
                mode_left = $urandom_range(120, 10);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                res_stall = 1'b1;
            end else begin
                case (mode)
                    0: res_stall = 1'b0;
                    1: res_stall = ($urandom_range(3) == 0);
                    default: res_stall = ($urandom_range(3) != 0);
                endcase
            end
        end
    end

    // one request, held until accepted, then a gap between bursts
    task automatic send_tri(t_tri_req r);
        int gap;
        tri_req   = r;
        tri_valid = 1'b1;
        do @(posedge clk); while (tri_stall);
        @(negedge clk);
        sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
            if (gap > 0) begin
                tri_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        tri_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_regs(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        logic [31:0] vals[6];
        vals = '{px, py, pz, dx, dy, dz};
        cur_px = px; cur_py = py; cur_pz = pz;
        for (int k = 0; k < 6; k++) begin
            cfg_we = 1'b1;
            cfg_index = 3'(k);
            cfg_data = vals[k];
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    function automatic t_tri_req tri_of(logic [15:0] idx, int x0, int y0, int z0, int x1,
                                        int y1, int z1, int x2, int y2, int z2, logic last);
        return '{idx, x0, y0, z0, x1, y1, z1, x2, y2, z2, last};
    endfunction

    // triangle around the point, mostly enclosing its projection
    function automatic t_tri_req near_tri(logic last);
        int r, zr;
        r  = 1 << $urandom_range(20, 4);
        zr = 1 << $urandom_range(27, 2);
        return tri_of(16'($urandom), cur_px - $urandom_range(r), cur_py - $urandom_range(r),
                      cur_pz + $signed($urandom_range(2 * zr)) - zr,
                      cur_px + $urandom_range(r), cur_py - $urandom_range(r),
                      cur_pz + $signed($urandom_range(2 * zr)) - zr,
                      cur_px + $signed($urandom_range(r)) - r / 2,
                      cur_py + $urandom_range(r) + 1,
                      cur_pz + $signed($urandom_range(2 * zr)) - zr, last);
    endfunction

    function automatic t_tri_req noise_tri(logic last);
        return tri_of(16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, last);
    endfunction

    task automatic random_scans(int count);
        int len, stop;
        stop = sent + count;
        while (sent < stop) begin
            len = $urandom_range(6, 1);
            for (int k = 1; k <= len; k++) begin
                if ($urandom_range(4) == 0)
                    send_tri(noise_tri(k == len || $urandom_range(30) == 0));
                else
                    send_tri(near_tri(k == len || $urandom_range(30) == 0));
            end
        end
    endtask

    localparam int ONE = 32'h0001_0000;

    initial begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_regs(0, 0, 0, 0, 0, DIR_Z_RESET);

        // directed: plain hit, degenerate, tie, miss, far hit, extremes
        send_tri(tri_of(16'd5, -ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 1'b1));
        send_tri(tri_of(16'd6, ONE, ONE, 0, ONE, ONE, 0, 2 * ONE, 0, 0, 1'b1));
        send_tri(tri_of(16'd7, -ONE, -ONE, 2 * ONE, ONE, -ONE, 2 * ONE, 0, ONE, 2 * ONE, 1'b0));
        send_tri(tri_of(16'd8, -ONE, -ONE, -2 * ONE, ONE, -ONE, -2 * ONE, 0, ONE, -2 * ONE,
                        1'b0));
        send_tri(tri_of(16'hFFFF, -ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 1'b1));
        send_tri(tri_of(16'd9, ONE, ONE, 0, 3 * ONE, ONE, 0, ONE, 3 * ONE, 0, 1'b1));
        send_tri(tri_of(16'd10, -ONE, -ONE, 2000 * ONE, ONE, -ONE, 2000 * ONE, 0, ONE,
                        2000 * ONE, 1'b1));
        send_tri(tri_of(16'd11, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 1'b1));
        send_tri(tri_of(16'd12, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 1'b1));
        send_tri(tri_of(16'd13, -1, -1, 32'h7FFF_FFFF, 1, -1, 32'h8000_0000, 0, 1, 0, 1'b1));
        send_tri(tri_of(16'd14, -ONE, -ONE, -1, ONE, -ONE, -1, 0, ONE, -1, 1'b1));
        send_tri(noise_tri(1'b1));
        drain();
        set_regs(ONE / 3, -ONE / 5, 7 * ONE, ONE / 4, -ONE / 8, ONE);
        send_tri(tri_of(16'd20, -2 * ONE, -2 * ONE, 0, 2 * ONE, -2 * ONE, ONE, 0, 2 * ONE,
                        -ONE, 1'b1));
        long_hold_req = 1'b1;
        random_scans(280);
        drain();

        // direction of zero length: every triangle degenerate
        set_regs(0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 4; k++) send_tri(near_tri(k == 3));
        drain();
        set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000);
        random_scans(60);
        drain();
        set_regs($urandom_range(8 * ONE), -$urandom_range(8 * ONE), $urandom,
                 $urandom_range(ONE), $urandom_range(ONE), 32'h8000_0000);
        random_scans(250);
        drain();
        set_regs(-3 * ONE, ONE, -ONE, 0, 0, -1);
        random_scans(N_ITEMS - sent);
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
